>>> rtl/mre_pkg.sv
// ----------------------------------------------------------------------------
// mre_pkg
// Types and constants shared by the color-key mask run extractor and its
// checker.
// ----------------------------------------------------------------------------
package mre_pkg;

    localparam int unsigned MAX_WIDTH     = 4096;
    localparam int unsigned MAX_HEIGHT    = 4096;
    localparam int unsigned PALETTE_DEPTH = 256;

    localparam int unsigned PAL_IDX_W = $clog2(PALETTE_DEPTH);
    localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned CFG_W     = 24;
    localparam int unsigned CFG_ADDR_W = 2;

    // request kinds
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_COLOR    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        FMT_PAL8  = 2'd0,
        FMT_RGB16 = 2'd1,
        FMT_RGB24 = 2'd2,
        FMT_RGB32 = 2'd3
    } pix_fmt_t;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  palette_index;
        logic [31:0] palette_word;
        logic [31:0] pixel_value;
    } pix_item_t;

    typedef struct packed {
        logic [11:0] run_left;
        logic [11:0] run_row;
        logic [12:0] run_right;
    } run_item_t;

endpackage

>>> rtl/mask_run_extractor_unit.sv
// ----------------------------------------------------------------------------
// mask_run_extractor_unit
// Compares pixels against a transparent key color and emits one run of
// opaque pixels per closing key pixel or line end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  pix     | in        | pix_valid / pix_stall   | pix_item (palette write or pixel)
//  run     | out       | run_valid / run_stall   | run_item (left, row, right)
//  cfg     | in        | cfg_wen                 | cfg_addr, cfg_wdata
//
// One item per clock while pix_stall is low. An accepted item loads stage 1 and the palette
// read register; a pixel's run then moves from stage 1 into the run output register, which
// drives run_valid, once that register is free.
// pix_stall rises only while a run waits in the output register and the stage behind
// it is full. Reset clears the counters, the open run and the valid flags and loads
// the configuration defaults; the palette and data registers hold no reset value.
// ----------------------------------------------------------------------------
module mask_run_extractor_unit
    import mre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_item_t             pix_item,
    output logic                  run_valid,
    input  logic                  run_stall,
    output run_item_t             run_item,
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    // configuration
    pix_fmt_t         fmt_reg;
    logic [23:0]      key_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // palette
    logic [31:0]      palette_mem [PALETTE_DEPTH];
    logic [31:0]      pal_rdata_reg;

    // stage 1
    logic             s1_valid_reg;
    logic             s1_is_pixel_reg;
    logic [31:0]      s1_pixel_reg;

    // scan state
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             open_reg, open_next;
    logic [COL_W-1:0] start_reg, start_next;

    // output register
    logic             out_valid_reg;
    run_item_t        out_item_reg;

    logic             pix_accept;
    logic             out_free;
    logic             s1_fire;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [31:0]      key_rgb;
    logic [15:0]      key_565;
    logic             opaque;
    logic             line_end;
    logic             close_run;
    logic             emit;
    run_item_t        emit_item;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    assign out_free   = !out_valid_reg || !run_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign pix_stall  = s1_valid_reg && !out_free;
    assign pix_accept = pix_valid && !pix_stall;

    assign run_valid = out_valid_reg;
    assign run_item  = out_item_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_RGB32;
            key_reg    <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_PIXEL_FORMAT: fmt_reg    <= pix_fmt_t'(cfg_wdata[1:0]);
                REG_KEY_COLOR:    key_reg    <= cfg_wdata;
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // palette write and read both happen when the item is accepted
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            if (pix_item.req_type == REQ_PALETTE)
            begin
                palette_mem[pix_item.palette_index[PAL_IDX_W-1:0]] <= pix_item.palette_word;
            end
            pal_rdata_reg <= palette_mem[pix_item.pixel_value[PAL_IDX_W-1:0]];
        end
    end

    // key swapped from BGR to RGB order, and packed to 5:6:5
    assign key_rgb = {8'h00, key_reg[7:0], key_reg[15:8], key_reg[23:16]};
    assign key_565 = {key_reg[7:3], key_reg[15:10], key_reg[23:19]};

    always_comb
    begin
        case (fmt_reg)
            FMT_PAL8:  opaque = pal_rdata_reg != key_rgb;
            FMT_RGB16: opaque = s1_pixel_reg[15:0] != key_565;
            FMT_RGB24: opaque = s1_pixel_reg[23:0] != key_rgb[23:0];
            default:   opaque = s1_pixel_reg != key_rgb;
        endcase
    end

    assign w_eff = clamp_dim(width_reg, MAX_W_DIM);
    assign h_eff = clamp_dim(height_reg, MAX_H_DIM);

    assign line_end  = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
    assign close_run = open_reg && !opaque;
    assign emit      = close_run || (line_end && opaque);

    always_comb
    begin
        start_next = start_reg;
        if (!open_reg && opaque)
        begin
            start_next = col_reg;
        end

        emit_item.run_left  = start_next;
        emit_item.run_row   = row_reg;
        emit_item.run_right = close_run ? DIM_W'(col_reg) : w_eff;

        open_next = opaque && !line_end;
        if (line_end)
        begin
            col_next = '0;
            if ((DIM_W'(row_reg) + DIM_W'(1)) >= h_eff)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // stage 1 holds the accepted item beside the palette read result until the output register is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_is_pixel_reg <= pix_item.req_type == REQ_PIXEL;
            s1_pixel_reg    <= pix_item.pixel_value;
        end
    end

    // scan state advances on pixels only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            open_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (s1_fire && s1_is_pixel_reg)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            open_reg  <= open_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && s1_is_pixel_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_pixel_reg && emit)
        begin
            out_item_reg <= emit_item;
        end
    end

endmodule

>>> rtl/mre_checker.sv
// ----------------------------------------------------------------------------
// mre_checker
// Port-level checks for the mask run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module mre_checker
    import mre_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pix_valid,
    input logic      pix_stall,
    input pix_item_t pix_item,
    input logic      run_valid,
    input logic      run_stall,
    input run_item_t run_item
);

    // hold a stalled run
    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(run_item))
        else $error("run item changed while stalled");

    // the pixel side backs up only behind a stalled run
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> run_valid && run_stall)
        else $error("pixel channel stalled without a stalled run");

    // a fresh run must trace back to an accepted pixel item
    a_run_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(run_valid) |->
            $past(pix_valid && !pix_stall && pix_item.req_type == REQ_PIXEL, 2))
        else $error("run without a preceding pixel item");

    // a run always ends past column zero
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> run_item.run_right != '0)
        else $error("run with zero right edge");

endmodule

bind mask_run_extractor_unit mre_checker u_mre_checker (.*);
